/* rtl/core/ffba_pkg.sv */
package ffba_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int SIZE_FIELD_BITS  = 16;
    localparam int INDEX_FIELD_BITS = 4;
    localparam int LEFT_FIELD_BITS  = 16;
    localparam int TOTAL_BITS       = 20;
    localparam int MASK_FIELD_BITS  = 16;
    localparam int KIND_BITS        = 2;
    localparam int STATUS_BITS      = 2;

    localparam logic [TOTAL_BITS-1:0] SUM_MAX = {TOTAL_BITS{1'b1}};

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_REQ    = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK     = 2'd0,
        STAT_NOFIT  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_REPORT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WASTE,
        ST_EMIT
    } state_t;

    typedef enum logic {
        ALU_ADD_ENTRY,
        ALU_ADD_LEFT
    } alu_op_t;

    typedef struct packed {
        logic fits;
        logic saturated;
    } alu_flags_t;

endpackage

/* rtl/core/ffba_ram.sv */
module ffba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ffba_alu.sv */
module ffba_alu #(
    parameter int SIZE_BITS = ffba_pkg::SIZE_BITS_DEF
) (
    input  ffba_pkg::alu_op_t                op,
    input  logic [SIZE_BITS-1:0]             entry,
    input  logic [SIZE_BITS-1:0]             req,
    input  logic [SIZE_BITS-1:0]             left,
    input  logic [ffba_pkg::TOTAL_BITS-1:0]  acc,
    output ffba_pkg::alu_flags_t             flags,
    output logic [SIZE_BITS-1:0]             diff,
    output logic [ffba_pkg::TOTAL_BITS-1:0]  sum
);

    localparam int SW = ((SIZE_BITS > ffba_pkg::TOTAL_BITS) ? SIZE_BITS
                                                            : ffba_pkg::TOTAL_BITS) + 1;

    logic [SIZE_BITS-1:0] addend;
    logic [SW-1:0]        sum_wide;

    always_comb
    begin
        case (op)
            ffba_pkg::ALU_ADD_ENTRY: addend = entry;
            ffba_pkg::ALU_ADD_LEFT:  addend = left;
            default:                 addend = entry;
        endcase
    end

    assign diff            = entry - req;
    assign sum_wide        = SW'(acc) + SW'(addend);
    assign flags.fits      = (entry >= req);
    assign flags.saturated = (sum_wide > SW'(ffba_pkg::SUM_MAX));
    assign sum             = flags.saturated ? ffba_pkg::SUM_MAX
                                             : sum_wide[ffba_pkg::TOTAL_BITS-1:0];

endmodule

/* rtl/core/first_fit_block_allocator.sv */
// first-fit block allocator
// input stream: s_axis_tuser carries the kind (load, request, report), s_axis_tdata
// the block or request size. output stream: m_axis_tuser the status, m_axis_tdata
// the index, leftover, waste total and free mask of one result word.
// a load goes to the emit state straight from idle. a request or a report walks the
// loaded table one entry per cycle through the size memory (one registered read
// port) and the shared compare/add unit; a grant ends the walk and passes through
// the waste state, which folds the leftover into the waste total. one word is in
// the scan at a time.
// a single output register holds the finished result; the next word is taken
// while it waits, but a new result is held back until the receiver takes the
// previous one, so a stalled receiver simply stops the block.
// reset clears the used flags, the block count and the waste total; sizes need
// no clearing since only loaded entries are ever read. kind 3 gives no result.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // size
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // block_index, leftover, total_waste, free_mask
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
    localparam int TB       = ffba_pkg::TOTAL_BITS;
    localparam int LW = (SIZE_BITS > ffba_pkg::SIZE_FIELD_BITS) ? SIZE_BITS
                                                                : ffba_pkg::SIZE_FIELD_BITS;
    localparam int IW = (IDX_BITS > ffba_pkg::INDEX_FIELD_BITS) ? IDX_BITS
                                                                : ffba_pkg::INDEX_FIELD_BITS;
    localparam int MW = (NUM_BLOCKS > ffba_pkg::MASK_FIELD_BITS) ? NUM_BLOCKS
                                                                 : ffba_pkg::MASK_FIELD_BITS;

    ffba_pkg::state_t  state_reg, state_next;
    ffba_pkg::kind_t   kind_reg, kind_next;
    logic [NUM_BLOCKS-1:0] used_reg, used_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [TB-1:0]         waste_reg, waste_next;
    logic [CNT_BITS-1:0]   issue_reg, issue_next;
    logic                  pend_reg, pend_next;
    logic [IDX_BITS-1:0]   pend_idx_reg, pend_idx_next;
    logic                  out_vld_reg, out_vld_next;

    logic [SIZE_BITS-1:0]  req_reg, req_next;
    logic [SIZE_BITS-1:0]  left_reg, left_next;
    logic [TB-1:0]         tot_reg, tot_next;
    logic [NUM_BLOCKS-1:0] mask_reg, mask_next;
    ffba_pkg::status_t     res_status_reg, res_status_next;
    logic [IDX_BITS-1:0]   res_idx_reg, res_idx_next;
    logic [SIZE_BITS-1:0]  res_left_reg, res_left_next;
    logic [TB-1:0]         res_total_reg, res_total_next;
    logic [NUM_BLOCKS-1:0] res_mask_reg, res_mask_next;

    logic [1:0]  out_status_reg, out_status_next;
    logic [3:0]  out_idx_reg, out_idx_next;
    logic [15:0] out_left_reg, out_left_next;
    logic [TB-1:0] out_total_reg, out_total_next;
    logic [15:0] out_mask_reg, out_mask_next;

    logic                 s_fire;
    logic [LW-1:0]        size_ext;
    logic [SIZE_BITS-1:0] size_in;
    logic                 ram_we;
    logic [IDX_BITS-1:0]  ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    ffba_pkg::alu_op_t    alu_op;
    logic [TB-1:0]        alu_acc;
    ffba_pkg::alu_flags_t alu_flags;
    logic [SIZE_BITS-1:0] alu_diff;
    logic [TB-1:0]        alu_sum;

    logic [IW-1:0]        idx_ext;
    logic [LW-1:0]        left_ext;
    logic [MW-1:0]        mask_ext;

    assign s_axis_tready = (state_reg == ffba_pkg::ST_IDLE);
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign size_ext = LW'(s_axis_tdata);
    assign size_in  = size_ext[SIZE_BITS-1:0];
    assign ram_raddr = issue_reg[IDX_BITS-1:0];
    assign idx_ext  = IW'(res_idx_reg);
    assign left_ext = LW'(res_left_reg);
    assign mask_ext = MW'(res_mask_reg);

    ffba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_BITS-1:0]),
        .wdata (size_in),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffba_alu #(
        .SIZE_BITS (SIZE_BITS)
    ) u_alu (
        .op    (alu_op),
        .entry (ram_rdata),
        .req   (req_reg),
        .left  (left_reg),
        .acc   (alu_acc),
        .flags (alu_flags),
        .diff  (alu_diff),
        .sum   (alu_sum)
    );

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        waste_next      = waste_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        req_next        = req_reg;
        left_next       = left_reg;
        tot_next        = tot_reg;
        mask_next       = mask_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_left_next   = res_left_reg;
        res_total_next  = res_total_reg;
        res_mask_next   = res_mask_reg;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_left_next   = out_left_reg;
        out_total_next  = out_total_reg;
        out_mask_next   = out_mask_reg;
        out_vld_next    = out_vld_reg && !m_axis_tready;
        ram_we          = 1'b0;
        alu_op          = ffba_pkg::ALU_ADD_ENTRY;
        alu_acc         = tot_reg;

        case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    kind_next      = ffba_pkg::kind_t'(s_axis_tuser);
                    req_next       = size_in;
                    issue_next     = '0;
                    pend_next      = 1'b0;
                    tot_next       = waste_reg;
                    mask_next      = '0;
                    res_idx_next   = '0;
                    res_left_next  = '0;
                    res_total_next = waste_reg;
                    res_mask_next  = '0;
                    case (ffba_pkg::kind_t'(s_axis_tuser))
                        ffba_pkg::KIND_LOAD:
                        begin
                            if (count_reg == CNT_BITS'(NUM_BLOCKS))
                            begin
                                res_status_next = ffba_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                used_next[count_reg[IDX_BITS-1:0]] = 1'b0;
                                count_next      = count_reg + 1'b1;
                                res_status_next = ffba_pkg::STAT_OK;
                                res_idx_next    = count_reg[IDX_BITS-1:0];
                            end
                            state_next = ffba_pkg::ST_EMIT;
                        end
                        ffba_pkg::KIND_REQ,
                        ffba_pkg::KIND_REPORT:
                        begin
                            state_next = ffba_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ffba_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            ffba_pkg::ST_SCAN:
            begin
                // read one entry per cycle, check the one read last cycle
                if (issue_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_BITS-1:0];
                    issue_next    = issue_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg && !used_reg[pend_idx_reg] && kind_reg == ffba_pkg::KIND_REQ
                    && alu_flags.fits)
                begin
                    used_next[pend_idx_reg] = 1'b1;
                    left_next    = alu_diff;
                    res_idx_next = pend_idx_reg;
                    pend_next    = 1'b0;
                    state_next   = ffba_pkg::ST_WASTE;
                end
                else if (pend_reg && !used_reg[pend_idx_reg]
                         && kind_reg == ffba_pkg::KIND_REPORT)
                begin
                    tot_next               = alu_sum;
                    mask_next[pend_idx_reg] = 1'b1;
                end
                else if (!pend_reg && !(issue_reg < count_reg))
                begin
                    res_idx_next  = '0;
                    res_left_next = '0;
                    if (kind_reg == ffba_pkg::KIND_REPORT)
                    begin
                        res_status_next = ffba_pkg::STAT_REPORT;
                        res_total_next  = tot_reg;
                        res_mask_next   = mask_reg;
                    end
                    else
                    begin
                        res_status_next = ffba_pkg::STAT_NOFIT;
                        res_total_next  = waste_reg;
                        res_mask_next   = '0;
                    end
                    state_next = ffba_pkg::ST_EMIT;
                end
            end

            ffba_pkg::ST_WASTE:
            begin
                alu_op          = ffba_pkg::ALU_ADD_LEFT;
                alu_acc         = waste_reg;
                waste_next      = alu_sum;
                res_status_next = ffba_pkg::STAT_OK;
                res_left_next   = left_reg;
                res_total_next  = alu_sum;
                res_mask_next   = '0;
                state_next      = ffba_pkg::ST_EMIT;
            end

            ffba_pkg::ST_EMIT:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next    = idx_ext[3:0];
                    out_left_next   = left_ext[15:0];
                    out_total_next  = res_total_reg;
                    out_mask_next   = mask_ext[15:0];
                    state_next      = ffba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ffba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffba_pkg::ST_IDLE;
            kind_reg     <= ffba_pkg::KIND_NONE;
            used_reg     <= '0;
            count_reg    <= '0;
            waste_reg    <= '0;
            issue_reg    <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            used_reg     <= used_next;
            count_reg    <= count_next;
            waste_reg    <= waste_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        left_reg       <= left_next;
        tot_reg        <= tot_next;
        mask_reg       <= mask_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_left_reg   <= res_left_next;
        res_total_reg  <= res_total_next;
        res_mask_reg   <= res_mask_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_left_reg   <= out_left_next;
        out_total_reg  <= out_total_next;
        out_mask_reg   <= out_mask_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_mask_reg, out_total_reg, out_left_reg, out_idx_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(NUM_BLOCKS))
        else $error("block count beyond table size");

    a_waste_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> waste_reg >= $past(waste_reg))
        else $error("waste total decreased");

    a_pend_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (CNT_BITS'(pend_idx_reg) < count_reg))
        else $error("scan read an unloaded entry");

    a_grant_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffba_pkg::ST_WASTE |-> used_reg[res_idx_reg])
        else $error("granted block not marked used");

endmodule

/* tb/sv/ffba_checker.sv */
module ffba_checker
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // size
    input  logic [1:0]  s_axis_tuser,   // kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // block_index, leftover, total_waste, free_mask
    input  logic [1:0]  m_axis_tuser,   // status
    output int          mismatch_count,
    output int          answers_pending
);

    typedef struct packed {
        status_t                     status;
        logic [INDEX_FIELD_BITS-1:0] index;
        logic [LEFT_FIELD_BITS-1:0]  leftover;
        logic [TOTAL_BITS-1:0]       total;
        logic [MASK_FIELD_BITS-1:0]  free_mask;
    } answer_t;

    logic [SIZE_FIELD_BITS-1:0] tbl_size [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]      tbl_used;
    int                         tbl_count;
    logic [TOTAL_BITS-1:0]      waste;
    answer_t                    answers_due [$];

    function automatic logic [TOTAL_BITS-1:0] clamp_sum(logic [TOTAL_BITS-1:0] a,
                                                        logic [SIZE_FIELD_BITS-1:0] b);
        logic [TOTAL_BITS:0] s;
        s = {1'b0, a} + b;
        return (s > SUM_MAX) ? SUM_MAX : s[TOTAL_BITS-1:0];
    endfunction

    // first-fit answer for one accepted word, table state updated in place
    task automatic first_fit_answer(kind_t k, logic [SIZE_FIELD_BITS-1:0] sz);
        answer_t                    a;
        logic                       found;
        logic [SIZE_FIELD_BITS-1:0] left;
        int                         i;
        a = '0;
        a.total = waste;
        found = 1'b0;
        case (k)
            KIND_LOAD:
            begin
                if (tbl_count >= NUM_BLOCKS)
                begin
                    a.status = STAT_FULL;
                end
                else
                begin
                    tbl_size[tbl_count] = sz;
                    tbl_used[tbl_count] = 1'b0;
                    a.status = STAT_OK;
                    a.index = tbl_count[INDEX_FIELD_BITS-1:0];
                    tbl_count++;
                end
            end
            KIND_REQ:
            begin
                a.status = STAT_NOFIT;
                for (i = 0; i < tbl_count; i++)
                begin
                    if (!found && !tbl_used[i] && tbl_size[i] >= sz)
                    begin
                        found = 1'b1;
                        left = tbl_size[i] - sz;
                        tbl_used[i] = 1'b1;
                        waste = clamp_sum(waste, left);
                        a.status = STAT_OK;
                        a.index = i[INDEX_FIELD_BITS-1:0];
                        a.leftover = left;
                        a.total = waste;
                    end
                end
            end
            KIND_REPORT:
            begin
                a.status = STAT_REPORT;
                for (i = 0; i < tbl_count; i++)
                begin
                    if (!tbl_used[i])
                    begin
                        a.total = clamp_sum(a.total, tbl_size[i]);
                        a.free_mask[i] = 1'b1;
                    end
                end
            end
            default:
            begin
                return;
            end
        endcase
        answers_due.push_back(a);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            tbl_used = '0;
            tbl_count = 0;
            waste = '0;
            answers_due.delete();
            mismatch_count = 0;
            answers_pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = status_t'(m_axis_tuser);
                got.index = m_axis_tdata[3:0];
                got.leftover = m_axis_tdata[19:4];
                got.total = m_axis_tdata[39:20];
                got.free_mask = m_axis_tdata[55:40];
                if (answers_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: status %0d idx %0d left %0h total %0h mask %0h",
                                 got.status, got.index, got.leftover, got.total, got.free_mask);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch exp: status %0d idx %0d left %0h total %0h mask %0h",
                                     want.status, want.index, want.leftover, want.total,
                                     want.free_mask);
                            $display("mismatch got: status %0d idx %0d left %0h total %0h mask %0h",
                                     got.status, got.index, got.leftover, got.total,
                                     got.free_mask);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                first_fit_answer(kind_t'(s_axis_tuser), s_axis_tdata);
            answers_pending = answers_due.size();
        end
    end

endmodule

/* tb/sv/first_fit_block_allocator_tb.sv */
module first_fit_block_allocator_tb;

    import ffba_pkg::*;

    localparam int WORD_COUNT = 1500;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int          mismatch_count;
    int          answers_pending;
    int          burst_left;
    int          sent;
    int          stall_pct;
    int          phase_left;
    bit          hold_req;

    first_fit_block_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ffba_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .answers_pending (answers_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one word at a falling edge, return at the falling edge after it is taken
    task automatic offer_word(kind_t k, logic [15:0] sz);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = k;
        s_axis_tdata = sz;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        if (k != KIND_NONE)
            sent++;
    endtask

    task automatic offer_random_word();
        int    r;
        kind_t k;
        logic [15:0] sz;
        r = $urandom_range(99);
        sz = 16'($urandom_range(0, 16'hFFFF));
        if (r < 8)
        begin
            k = KIND_LOAD;
        end
        else if (r < 70)
        begin
            k = KIND_REQ;
            r = $urandom_range(99);
            // mostly large requests so blocks are not used up early
            if (r < 2)
                sz = 16'($urandom_range(0, 255));
            else if (r >= 5)
                sz = 16'($urandom_range(16'hF000, 16'hFFFF));
        end
        else if (r < 92)
        begin
            k = KIND_REPORT;
        end
        else
        begin
            k = KIND_NONE;
        end
        offer_word(k, sz);
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        stall_pct = 0;
        phase_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (400) @(negedge clk);
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(16, 128);
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_left--;
            m_axis_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_LOAD;
        hold_req = 1'b0;
        burst_left = 0;
        sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table, unused kind, size extremes, zero request, exact fit
        offer_word(KIND_REPORT, 16'h0000);
        offer_word(KIND_REQ, 16'h0000);
        offer_word(KIND_NONE, 16'hFFFF);
        offer_word(KIND_LOAD, 16'hFFFF);
        offer_word(KIND_LOAD, 16'h0000);
        offer_word(KIND_LOAD, 16'h8000);
        offer_word(KIND_LOAD, 16'h00FF);
        offer_word(KIND_LOAD, 16'h5555);
        offer_word(KIND_LOAD, 16'hAAAA);
        offer_word(KIND_REPORT, 16'hFFFF);
        offer_word(KIND_REQ, 16'h0000);
        offer_word(KIND_REQ, 16'h0000);
        offer_word(KIND_REQ, 16'hFFFF);
        offer_word(KIND_REQ, 16'h8000);
        offer_word(KIND_REQ, 16'h5556);
        offer_word(KIND_REQ, 16'h00FF);
        offer_word(KIND_REPORT, 16'h0000);
        offer_word(KIND_NONE, 16'h0000);

        while (sent < WORD_COUNT)
        begin
            if (sent == 300 || sent == 1100)
                hold_req = 1'b1;
            if (sent == 800)
            begin
                s_axis_tvalid = 1'b0;
                wait (answers_pending == 0);
                @(negedge clk);
                burst_left = 0;
            end
            offer_random_word();
        end
        s_axis_tvalid = 1'b0;

        wait (answers_pending == 0);
        repeat (NUM_BLOCKS_DEF + 8) @(posedge clk);
        if (mismatch_count == 0 && answers_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
